[hdl/tile_map_scroll_viewport_core_macros.svh]
// Assertion macros used by the tile map viewport back end.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef TILE_MAP_SCROLL_VIEWPORT_CORE_MACROS_SVH
`define TILE_MAP_SCROLL_VIEWPORT_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define TMSV_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("%m: same-cycle check failed");
// next-cycle implication
`define TMSV_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("%m: next-cycle check failed");
`else
`define TMSV_ASSERT_IMPL(label, ante, cons)
`define TMSV_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[hdl/tmsv_pkg.sv]
`default_nettype none
package tmsv_pkg;

	// field widths
	localparam int DIM_W   = 13;
	localparam int COORD_W = 16;
	localparam int STEP_W  = 10;
	localparam int IDX_W   = 16;

	localparam logic [COORD_W-1:0] COORD_MAX = 16'hffff;
	localparam logic [15:0]        NO_TILE   = 16'hffff;

	// parameter defaults
	localparam int DEF_TILE_SHIFT_X = 3;
	localparam int DEF_TILE_SHIFT_Y = 3;
	localparam int DEF_MAP_TILES    = 4096;

	// request types
	localparam logic [1:0] REQ_REL   = 2'd0;
	localparam logic [1:0] REQ_SET   = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;
	localparam logic [1:0] REQ_WRITE = 2'd3;

	// coordinate spaces
	localparam logic [1:0] SP_MAP    = 2'd0;
	localparam logic [1:0] SP_VIEW   = 2'd1;
	localparam logic [1:0] SP_SCREEN = 2'd2;

	// store operation carried to the back end
	localparam logic [1:0] OP_NONE  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_MISS  = 2'd2;
	localparam logic [1:0] OP_WRITE = 2'd3;

	// register indexes
	localparam logic [2:0] REG_MAP_WIDTH  = 3'd0;
	localparam logic [2:0] REG_MAP_HEIGHT = 3'd1;
	localparam logic [2:0] REG_VIEW_LEFT  = 3'd2;
	localparam logic [2:0] REG_VIEW_TOP   = 3'd3;
	localparam logic [2:0] REG_VIEW_W     = 3'd4;
	localparam logic [2:0] REG_VIEW_H     = 3'd5;
	localparam logic [2:0] REG_TILE_LIMIT = 3'd6;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [DIM_W-1:0]   map_width;
		logic [DIM_W-1:0]   map_height;
		logic [COORD_W-1:0] view_left;
		logic [COORD_W-1:0] view_top;
		logic [COORD_W-1:0] view_width;
		logic [COORD_W-1:0] view_height;
		logic [15:0]        tile_limit;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         op;
		logic               outside;
		logic [3:0]         edge_flags;
		logic [IDX_W-1:0]   idx;
		logic [15:0]        wdata;
		logic [COORD_W-1:0] sx;
		logic [COORD_W-1:0] sy;
	} qent_t;

endpackage
`default_nettype wire

[hdl/tmsv_front.sv]
`default_nettype none
// Front end: accepts words, runs scroll moves, resolves tile coordinates.
module tmsv_front #(
	parameter int TILE_SHIFT_X = tmsv_pkg::DEF_TILE_SHIFT_X,
	parameter int TILE_SHIFT_Y = tmsv_pkg::DEF_TILE_SHIFT_Y,
	parameter int MAP_TILES    = tmsv_pkg::DEF_MAP_TILES
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire tmsv_pkg::cfg_t       cfg,
	input  wire logic                 blocked,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [1:0]           req_type,
	input  wire logic [1:0]           coord_space,
	input  wire logic [3:0]           dir_mask,
	input  wire logic [9:0]           step_count,
	input  wire logic [15:0]          pos_x,
	input  wire logic [15:0]          pos_y,
	input  wire logic [15:0]          tile_value,
	output logic                      q_valid,
	input  wire logic                 q_ready,
	output tmsv_pkg::qent_t           q_data
);

	localparam int SX = TILE_SHIFT_X;
	localparam int SY = TILE_SHIFT_Y;
	localparam int PXW_X = (tmsv_pkg::DIM_W + SX > tmsv_pkg::COORD_W) ?
		tmsv_pkg::DIM_W + SX : tmsv_pkg::COORD_W;
	localparam int PXW_Y = (tmsv_pkg::DIM_W + SY > tmsv_pkg::COORD_W) ?
		tmsv_pkg::DIM_W + SY : tmsv_pkg::COORD_W;

	// move toward zero; result {flag, pos}
	function automatic logic [16:0] move_up(input logic [15:0] pos, input logic [9:0] steps);
		logic [15:0] st;
		st = {6'd0, steps};
		if (st > pos) return {1'b1, 16'd0};
		return {1'b0, pos - st};
	endfunction

	// move toward limit; result {flag, pos}
	function automatic logic [16:0] move_down(input logic [15:0] pos, input logic [9:0] steps,
		input logic [15:0] lim);
		logic [16:0] sum;
		sum = {1'b0, pos} + {7'd0, steps};
		if (pos >= lim) return {steps != 10'd0, pos};
		if (sum > {1'b0, lim}) return {1'b1, lim};
		return {1'b0, sum[15:0]};
	endfunction

	logic        acc, adv;
	logic        valid_s1;
	logic [15:0] sx_q, sy_q;

	// scroll limits
	logic [PXW_X-1:0] pix_x, mrg_x;
	logic [PXW_Y-1:0] pix_y, mrg_y;
	logic [15:0]      max_x, max_y;

	always_comb begin
		pix_x = PXW_X'(cfg.map_width) << SX;
		pix_y = PXW_Y'(cfg.map_height) << SY;
		mrg_x = (pix_x > PXW_X'(cfg.view_width)) ? pix_x - PXW_X'(cfg.view_width) : '0;
		mrg_y = (pix_y > PXW_Y'(cfg.view_height)) ? pix_y - PXW_Y'(cfg.view_height) : '0;
		max_x = (mrg_x > PXW_X'(tmsv_pkg::COORD_MAX)) ? tmsv_pkg::COORD_MAX : mrg_x[15:0];
		max_y = (mrg_y > PXW_Y'(tmsv_pkg::COORD_MAX)) ? tmsv_pkg::COORD_MAX : mrg_y[15:0];
	end

	// scroll update: up, down, left, right in that order
	logic [16:0] y_up, y_dn, x_lf, x_rt;
	logic [15:0] y1, x1, sx_nxt, sy_nxt;
	logic [3:0]  flags;

	always_comb begin
		y_up = move_up(sy_q, step_count);
		y1 = dir_mask[0] ? y_up[15:0] : sy_q;
		y_dn = move_down(y1, step_count, max_y);
		x_lf = move_up(sx_q, step_count);
		x1 = dir_mask[2] ? x_lf[15:0] : sx_q;
		x_rt = move_down(x1, step_count, max_x);
		sx_nxt = sx_q;
		sy_nxt = sy_q;
		flags = 4'd0;
		unique case (req_type)
			tmsv_pkg::REQ_REL: begin
				sy_nxt = dir_mask[1] ? y_dn[15:0] : y1;
				sx_nxt = dir_mask[3] ? x_rt[15:0] : x1;
				flags = {dir_mask[3] & x_rt[16], dir_mask[2] & x_lf[16],
					dir_mask[1] & y_dn[16], dir_mask[0] & y_up[16]};
			end
			tmsv_pkg::REQ_SET: begin
				sx_nxt = pos_x;
				sy_nxt = pos_y;
			end
			tmsv_pkg::REQ_READ, tmsv_pkg::REQ_WRITE: begin
			end
		endcase
	end

	// coordinate to map column and row
	logic [16:0] lx, ly, x_end, y_end, col17, row17;
	logic        loc_out, pre_out;

	always_comb begin
		x_end = {1'b0, cfg.view_left} + {1'b0, cfg.view_width};
		y_end = {1'b0, cfg.view_top} + {1'b0, cfg.view_height};
		lx = {1'b0, pos_x};
		ly = {1'b0, pos_y};
		loc_out = 1'b0;
		unique case (coord_space)
			tmsv_pkg::SP_MAP: begin
			end
			tmsv_pkg::SP_VIEW: begin
				lx = {1'b0, pos_x} + {1'b0, sx_q};
				ly = {1'b0, pos_y} + {1'b0, sy_q};
			end
			tmsv_pkg::SP_SCREEN: begin
				loc_out = (pos_x < cfg.view_left) || (pos_y < cfg.view_top) ||
					({1'b0, pos_x} >= x_end) || ({1'b0, pos_y} >= y_end);
				lx = {1'b0, pos_x - cfg.view_left} + {1'b0, sx_q};
				ly = {1'b0, pos_y - cfg.view_top} + {1'b0, sy_q};
			end
			default: begin
				loc_out = 1'b1;
			end
		endcase
		col17 = lx >> SX;
		row17 = ly >> SY;
		pre_out = loc_out || (col17 >= 17'(cfg.map_width)) || (row17 >= 17'(cfg.map_height));
	end

	assign adv = valid_s1 && q_ready;
	assign in_ready = !blocked && (!valid_s1 || q_ready);
	assign acc = in_valid && in_ready;

	// scroll state and stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q <= '0;
			sy_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (acc) begin
				sx_q <= sx_nxt;
				sy_q <= sy_nxt;
			end
			if (acc) valid_s1 <= 1'b1;
			else if (adv) valid_s1 <= 1'b0;
		end
	end

	logic [1:0]              kind_s1;
	logic                    wr_ok_s1, out_s1;
	logic [tmsv_pkg::DIM_W-1:0] col_s1, row_s1;
	logic [15:0]             tv_s1, sx_s1, sy_s1;
	logic [3:0]              flags_s1;

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (acc) begin
			kind_s1 <= req_type;
			wr_ok_s1 <= tile_value < cfg.tile_limit;
			out_s1 <= pre_out;
			col_s1 <= col17[tmsv_pkg::DIM_W-1:0];
			row_s1 <= row17[tmsv_pkg::DIM_W-1:0];
			tv_s1 <= tile_value;
			flags_s1 <= flags;
			sx_s1 <= sx_nxt;
			sy_s1 <= sy_nxt;
		end
	end

	// store index and final classification
	logic [25:0] prod;
	logic [26:0] idx_full;
	logic        miss;

	always_comb begin
		prod = 26'(row_s1) * 26'(cfg.map_width);
		idx_full = {1'b0, prod} + 27'(col_s1);
		miss = out_s1 || (idx_full >= 27'(MAP_TILES));
		q_data.idx = idx_full[tmsv_pkg::IDX_W-1:0];
		q_data.wdata = tv_s1;
		q_data.edge_flags = flags_s1;
		q_data.sx = sx_s1;
		q_data.sy = sy_s1;
		q_data.op = tmsv_pkg::OP_NONE;
		q_data.outside = 1'b0;
		unique case (kind_s1)
			tmsv_pkg::REQ_REL, tmsv_pkg::REQ_SET: begin
			end
			tmsv_pkg::REQ_READ: begin
				q_data.op = miss ? tmsv_pkg::OP_MISS : tmsv_pkg::OP_READ;
				q_data.outside = miss;
			end
			tmsv_pkg::REQ_WRITE: begin
				q_data.op = (wr_ok_s1 && !miss) ? tmsv_pkg::OP_WRITE : tmsv_pkg::OP_NONE;
				q_data.outside = wr_ok_s1 && miss;
			end
		endcase
	end

	assign q_valid = valid_s1;

endmodule
`default_nettype wire

[hdl/tmsv_queue.sv]
`default_nettype none
// Small FIFO between front and back ends.
module tmsv_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push_valid,
	output logic                 push_ready,
	input  wire tmsv_pkg::qent_t push_data,
	output logic                 pop_valid,
	input  wire logic            pop_ready,
	output tmsv_pkg::qent_t      pop_data
);

	localparam int DEPTH = tmsv_pkg::QUEUE_DEPTH;
	localparam int PW    = $clog2(DEPTH);

	tmsv_pkg::qent_t ent_q [DEPTH];
	logic [PW-1:0]   wp_q, rp_q;
	logic [PW:0]     cnt_q;
	logic            push, pop;

	assign push_ready = cnt_q != (PW+1)'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign push = push_valid && push_ready;
	assign pop  = pop_valid && pop_ready;
	assign pop_data = ent_q[rp_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= push_data;
	end

endmodule
`default_nettype wire

[hdl/tmsv_back.sv]
`default_nettype none
`include "tile_map_scroll_viewport_core_macros.svh"
// Back end: tile store access, clear sweep, output register.
module tmsv_back #(
	parameter int TILE_SHIFT_X = tmsv_pkg::DEF_TILE_SHIFT_X,
	parameter int TILE_SHIFT_Y = tmsv_pkg::DEF_TILE_SHIFT_Y,
	parameter int MAP_TILES    = tmsv_pkg::DEF_MAP_TILES
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire tmsv_pkg::cfg_t  cfg,
	output logic                 busy,
	input  wire logic            q_valid,
	output logic                 q_ready,
	input  wire tmsv_pkg::qent_t q_data,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [3:0]           edge_flags,
	output logic [15:0]          tile_read,
	output logic                 outside,
	output logic [12:0]          first_col,
	output logic [12:0]          first_row,
	output logic [7:0]           fine_x,
	output logic [7:0]           fine_y,
	output logic [13:0]          cols_to_draw,
	output logic [13:0]          rows_to_draw,
	output logic [15:0]          scroll_now_x,
	output logic [15:0]          scroll_now_y
);

	localparam int SX   = TILE_SHIFT_X;
	localparam int SY   = TILE_SHIFT_Y;
	localparam int IW   = $clog2(MAP_TILES);
	localparam int TS_X = 1 << SX;
	localparam int TS_Y = 1 << SY;
	localparam logic [15:0] FMASK_X = 16'(TS_X - 1);
	localparam logic [15:0] FMASK_Y = 16'(TS_Y - 1);

	logic          clr_busy_q;
	logic [IW-1:0] clr_idx_q;
	logic          pop;
	logic [IW-1:0] addr;

	logic [15:0] mem_q [MAP_TILES];
	logic [15:0] rd_q;

	logic        out_valid_q, outside_q;
	logic [1:0]  op_q;
	logic [3:0]  flags_q;
	logic [15:0] sx_q, sy_q;

	assign busy = clr_busy_q;
	assign q_ready = !out_valid_q || out_ready;
	assign pop = q_valid && q_ready;
	assign addr = q_data.idx[IW-1:0];

	// clear sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == IW'(MAP_TILES - 1)) clr_busy_q <= 1'b0;
		end
	end

	// tile store: one write port shared with the sweep, registered read
	always_ff @(posedge clk) begin
		if (clr_busy_q) mem_q[clr_idx_q] <= 16'd0;
		else if (pop && q_data.op == tmsv_pkg::OP_WRITE) mem_q[addr] <= q_data.wdata;
		if (pop && q_data.op == tmsv_pkg::OP_READ) rd_q <= mem_q[addr];
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (pop) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (pop) begin
			op_q <= q_data.op;
			outside_q <= q_data.outside;
			flags_q <= q_data.edge_flags;
			sx_q <= q_data.sx;
			sy_q <= q_data.sy;
		end
	end

	// derived view fields
	logic [15:0] fx16, fy16;
	logic [16:0] cw_sum, rh_sum;

	always_comb begin
		fx16 = sx_q & FMASK_X;
		fy16 = sy_q & FMASK_Y;
		cw_sum = {1'b0, cfg.view_width} + {1'b0, fx16} + 17'(TS_X - 1);
		rh_sum = {1'b0, cfg.view_height} + {1'b0, fy16} + 17'(TS_Y - 1);
		unique case (op_q)
			tmsv_pkg::OP_READ:  tile_read = rd_q;
			tmsv_pkg::OP_MISS:  tile_read = tmsv_pkg::NO_TILE;
			tmsv_pkg::OP_NONE,
			tmsv_pkg::OP_WRITE: tile_read = 16'd0;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign edge_flags   = flags_q;
	assign outside      = outside_q;
	assign first_col    = 13'(sx_q >> SX);
	assign first_row    = 13'(sy_q >> SY);
	assign fine_x       = fx16[7:0];
	assign fine_y       = fy16[7:0];
	assign cols_to_draw = 14'(cw_sum >> SX);
	assign rows_to_draw = 14'(rh_sum >> SY);
	assign scroll_now_x = sx_q;
	assign scroll_now_y = sy_q;

	// checks
	`TMSV_ASSERT_IMPL(a_no_word_in_clear, clr_busy_q, !q_valid)
	`TMSV_ASSERT_NEXT(a_pop_loads_out, pop, out_valid_q)
	`TMSV_ASSERT_IMPL(a_clear_full_sweep, $fell(clr_busy_q), $past(clr_idx_q) == IW'(MAP_TILES - 1))
	`TMSV_ASSERT_IMPL(a_write_is_inside, out_valid_q && op_q == tmsv_pkg::OP_WRITE, !outside_q)

endmodule
`default_nettype wire

[hdl/tile_map_scroll_viewport_core.sv]
`default_nettype none
// Tile map background layer with a scrolling viewport.
// Request channel: in_valid/in_ready with one word per request (relative
// scroll, set scroll, tile read, tile write). Result channel: out_valid/
// out_ready, exactly one word per request, in request order.
// Config channel: cfg_valid/cfg_ready, cfg_index selects the register,
// cfg_data is the value; always ready, write only while the block is idle.
// Path: front stage register, queue entry, output register. Throughput:
// one word per cycle while out_ready is high and no sweep runs; each word
// passes the front stage, one queue slot, at most one tile store access.
// Reset: scroll goes to 0, registers take their defaults, and the tile
// store is swept to zero, one entry a cycle over all MAP_TILES entries,
// with in_ready low until the sweep ends.
// Stall: when out_ready is low the result stays in the output register;
// the 4-entry queue and the front stage keep filling, and in_ready drops
// once both are full.
module tile_map_scroll_viewport_core #(
	parameter int TILE_SHIFT_X = tmsv_pkg::DEF_TILE_SHIFT_X,
	parameter int TILE_SHIFT_Y = tmsv_pkg::DEF_TILE_SHIFT_Y,
	parameter int MAP_TILES    = tmsv_pkg::DEF_MAP_TILES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  req_type,
	input  wire logic [1:0]  coord_space,
	input  wire logic [3:0]  dir_mask,
	input  wire logic [9:0]  step_count,
	input  wire logic [15:0] pos_x,
	input  wire logic [15:0] pos_y,
	input  wire logic [15:0] tile_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       edge_flags,
	output logic [15:0]      tile_read,
	output logic             outside,
	output logic [12:0]      first_col,
	output logic [12:0]      first_row,
	output logic [7:0]       fine_x,
	output logic [7:0]       fine_y,
	output logic [13:0]      cols_to_draw,
	output logic [13:0]      rows_to_draw,
	output logic [15:0]      scroll_now_x,
	output logic [15:0]      scroll_now_y
);

	tmsv_pkg::cfg_t  cfg_q;
	tmsv_pkg::qent_t fq_data, qb_data;
	logic            fq_valid, fq_ready, qb_valid, qb_ready, busy;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.map_width <= 13'd64;
			cfg_q.map_height <= 13'd64;
			cfg_q.view_left <= 16'd0;
			cfg_q.view_top <= 16'd0;
			cfg_q.view_width <= 16'd320;
			cfg_q.view_height <= 16'd240;
			cfg_q.tile_limit <= 16'd256;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tmsv_pkg::REG_MAP_WIDTH:  cfg_q.map_width <= cfg_data[12:0];
				tmsv_pkg::REG_MAP_HEIGHT: cfg_q.map_height <= cfg_data[12:0];
				tmsv_pkg::REG_VIEW_LEFT:  cfg_q.view_left <= cfg_data;
				tmsv_pkg::REG_VIEW_TOP:   cfg_q.view_top <= cfg_data;
				tmsv_pkg::REG_VIEW_W:     cfg_q.view_width <= cfg_data;
				tmsv_pkg::REG_VIEW_H:     cfg_q.view_height <= cfg_data;
				tmsv_pkg::REG_TILE_LIMIT: cfg_q.tile_limit <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	tmsv_front #(
		.TILE_SHIFT_X(TILE_SHIFT_X),
		.TILE_SHIFT_Y(TILE_SHIFT_Y),
		.MAP_TILES(MAP_TILES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.blocked(busy),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.coord_space(coord_space),
		.dir_mask(dir_mask),
		.step_count(step_count),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.tile_value(tile_value),
		.q_valid(fq_valid),
		.q_ready(fq_ready),
		.q_data(fq_data)
	);

	tmsv_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(fq_valid),
		.push_ready(fq_ready),
		.push_data(fq_data),
		.pop_valid(qb_valid),
		.pop_ready(qb_ready),
		.pop_data(qb_data)
	);

	tmsv_back #(
		.TILE_SHIFT_X(TILE_SHIFT_X),
		.TILE_SHIFT_Y(TILE_SHIFT_Y),
		.MAP_TILES(MAP_TILES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.busy(busy),
		.q_valid(qb_valid),
		.q_ready(qb_ready),
		.q_data(qb_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.edge_flags(edge_flags),
		.tile_read(tile_read),
		.outside(outside),
		.first_col(first_col),
		.first_row(first_row),
		.fine_x(fine_x),
		.fine_y(fine_y),
		.cols_to_draw(cols_to_draw),
		.rows_to_draw(rows_to_draw),
		.scroll_now_x(scroll_now_x),
		.scroll_now_y(scroll_now_y)
	);

endmodule
`default_nettype wire

[test/testbench.sv]
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TSX = tmsv_pkg::DEF_TILE_SHIFT_X;
	localparam int TSY = tmsv_pkg::DEF_TILE_SHIFT_Y;
	localparam int MAP_CELLS = tmsv_pkg::DEF_MAP_TILES;
	localparam int CELL_W = $clog2(MAP_CELLS);

	// coordinate space with no meaning: every access falls outside the map
	localparam logic [1:0] SP_NONE = 2'd3;

	localparam logic [3:0] DIR_UP    = 4'b0001;
	localparam logic [3:0] DIR_DOWN  = 4'b0010;
	localparam logic [3:0] DIR_LEFT  = 4'b0100;
	localparam logic [3:0] DIR_RIGHT = 4'b1000;

	typedef struct {
		logic [1:0]  kind;
		logic [1:0]  space;
		logic [3:0]  dirs;
		logic [9:0]  steps;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] tile;
	} req_t;

	typedef struct {
		logic [3:0]  edges;
		logic [15:0] rd;
		logic        miss;
		logic [12:0] col;
		logic [12:0] row;
		logic [7:0]  fx;
		logic [7:0]  fy;
		logic [13:0] ncols;
		logic [13:0] nrows;
		logic [15:0] sx;
		logic [15:0] sy;
	} layer_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  req_type = '0;
	logic [1:0]  coord_space = '0;
	logic [3:0]  dir_mask = '0;
	logic [9:0]  step_count = '0;
	logic [15:0] pos_x = '0;
	logic [15:0] pos_y = '0;
	logic [15:0] tile_value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [3:0]  edge_flags;
	logic [15:0] tile_read;
	logic        outside;
	logic [12:0] first_col;
	logic [12:0] first_row;
	logic [7:0]  fine_x;
	logic [7:0]  fine_y;
	logic [13:0] cols_to_draw;
	logic [13:0] rows_to_draw;
	logic [15:0] scroll_now_x;
	logic [15:0] scroll_now_y;

	tile_map_scroll_viewport_core dut (
		.clk, .arst_n,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.in_valid, .in_ready,
		.req_type, .coord_space, .dir_mask, .step_count, .pos_x, .pos_y, .tile_value,
		.out_valid, .out_ready,
		.edge_flags, .tile_read, .outside, .first_col, .first_row, .fine_x, .fine_y,
		.cols_to_draw, .rows_to_draw, .scroll_now_x, .scroll_now_y
	);

	// mirror of the layer
	tmsv_pkg::cfg_t regs_now;
	int unsigned scroll_x;
	int unsigned scroll_y;
	logic [15:0] tile_mirror [MAP_CELLS];

	layer_out_t  due_views[$];
	int          mismatches = 0;
	int          requests_sent = 0;
	int          settings_used = 0;
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	int          hold_left = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// largest scroll along one axis
	function automatic int unsigned scroll_limit(int unsigned tiles, int shift,
			int unsigned view);
		int unsigned pix, room;
		pix = tiles << shift;
		room = (pix > view) ? pix - view : 0;
		return (room > 65535) ? 65535 : room;
	endfunction

	function automatic int unsigned retreat(int unsigned pos, int unsigned steps,
			output bit hit);
		hit = (steps > pos);
		return hit ? 0 : pos - steps;
	endfunction

	// positions already past the limit stay put
	function automatic int unsigned advance(int unsigned pos, int unsigned steps,
			int unsigned lim, output bit hit);
		hit = 1'b0;
		if (pos >= lim) begin
			hit = (steps != 0);
			return pos;
		end
		if (pos + steps > lim) begin
			hit = 1'b1;
			return lim;
		end
		return pos + steps;
	endfunction

	function automatic int unsigned span_tiles(int unsigned view, int unsigned fine, int shift);
		int unsigned whole, rest, carry;
		whole = view >> shift;
		rest = view - (whole << shift) + fine;
		carry = (rest >= (1 << shift)) ? 1 : 0;
		if (carry != 0)
			rest -= (1 << shift);
		return whole + carry + ((rest != 0) ? 1 : 0);
	endfunction

	// coordinate to store cell; 0 when it falls outside
	function automatic bit find_cell(logic [1:0] space, int unsigned x, int unsigned y,
			output int unsigned slot);
		int unsigned col, row, vl, vt, mw, mh;
		slot = 0;
		vl = 32'(regs_now.view_left);
		vt = 32'(regs_now.view_top);
		mw = 32'(regs_now.map_width);
		mh = 32'(regs_now.map_height);
		case (space)
		tmsv_pkg::SP_MAP: ;
		tmsv_pkg::SP_VIEW: begin
			x += scroll_x;
			y += scroll_y;
		end
		tmsv_pkg::SP_SCREEN: begin
			if (x < vl || y < vt)
				return 1'b0;
			if (x >= vl + regs_now.view_width || y >= vt + regs_now.view_height)
				return 1'b0;
			x = x - vl + scroll_x;
			y = y - vt + scroll_y;
		end
		default: return 1'b0;
		endcase
		col = x >> TSX;
		row = y >> TSY;
		if (col >= mw || row >= mh)
			return 1'b0;
		slot = row * mw + col;
		return slot < MAP_CELLS;
	endfunction

	// applies one request to the mirror and returns the word it should produce
	function automatic layer_out_t predict_layer(req_t r);
		layer_out_t  o;
		int unsigned lim_x, lim_y, slot, fx, fy;
		bit          hit;
		o = '{default: '0};
		case (r.kind)
		tmsv_pkg::REQ_REL: begin
			lim_x = scroll_limit(32'(regs_now.map_width), TSX, 32'(regs_now.view_width));
			lim_y = scroll_limit(32'(regs_now.map_height), TSY, 32'(regs_now.view_height));
			if ((r.dirs & DIR_UP) != 0) begin
				scroll_y = retreat(scroll_y, 32'(r.steps), hit);
				o.edges[0] = hit;
			end
			if ((r.dirs & DIR_DOWN) != 0) begin
				scroll_y = advance(scroll_y, 32'(r.steps), lim_y, hit);
				o.edges[1] = hit;
			end
			if ((r.dirs & DIR_LEFT) != 0) begin
				scroll_x = retreat(scroll_x, 32'(r.steps), hit);
				o.edges[2] = hit;
			end
			if ((r.dirs & DIR_RIGHT) != 0) begin
				scroll_x = advance(scroll_x, 32'(r.steps), lim_x, hit);
				o.edges[3] = hit;
			end
		end
		tmsv_pkg::REQ_SET: begin
			scroll_x = 32'(r.x);
			scroll_y = 32'(r.y);
		end
		tmsv_pkg::REQ_READ: begin
			if (find_cell(r.space, 32'(r.x), 32'(r.y), slot)) begin
				o.rd = tile_mirror[slot[CELL_W-1:0]];
			end else begin
				o.rd = tmsv_pkg::NO_TILE;
				o.miss = 1'b1;
			end
		end
		default: begin
			// codes at or above the limit are dropped without a miss
			if (r.tile < regs_now.tile_limit) begin
				if (find_cell(r.space, 32'(r.x), 32'(r.y), slot))
					tile_mirror[slot[CELL_W-1:0]] = r.tile;
				else
					o.miss = 1'b1;
			end
		end
		endcase
		fx = scroll_x & ((1 << TSX) - 1);
		fy = scroll_y & ((1 << TSY) - 1);
		o.col = 13'(scroll_x >> TSX);
		o.row = 13'(scroll_y >> TSY);
		o.fx = 8'(fx);
		o.fy = 8'(fy);
		o.ncols = 14'(span_tiles(32'(regs_now.view_width), fx, TSX));
		o.nrows = 14'(span_tiles(32'(regs_now.view_height), fy, TSY));
		o.sx = 16'(scroll_x);
		o.sy = 16'(scroll_y);
		return o;
	endfunction

	function automatic req_t make_req(logic [1:0] kind, logic [1:0] space, logic [3:0] dirs,
			logic [9:0] steps, logic [15:0] x, logic [15:0] y, logic [15:0] tile);
		req_t r;
		r.kind = kind;
		r.space = space;
		r.dirs = dirs;
		r.steps = steps;
		r.x = x;
		r.y = y;
		r.tile = tile;
		return r;
	endfunction

	// mostly near lo, some in a small corner, a few anywhere
	function automatic logic [15:0] pick_coord(int unsigned lo, int unsigned span);
		int unsigned v;
		case ($urandom_range(0, 9))
		0: v = $urandom_range(0, 65535);
		1, 2, 3: v = $urandom_range(0, 63);
		default: v = lo + $urandom_range(0, span + 16);
		endcase
		if (v >= 8 && $urandom_range(0, 7) == 0)
			v -= 8;
		return (v > 65535) ? 16'hffff : v[15:0];
	endfunction

	function automatic req_t random_request();
		req_t        r;
		int unsigned map_w, map_h;
		r.kind = 2'($urandom_range(0, 3));
		r.space = ($urandom_range(0, 9) == 0) ? SP_NONE : 2'($urandom_range(0, 2));
		r.dirs = 4'($urandom_range(0, 15));
		r.steps = 10'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) :
			$urandom_range(0, 40));
		if ($urandom_range(0, 4) == 0)
			r.tile = 16'($urandom_range(0, 65535));
		else
			r.tile = 16'($urandom_range(0, regs_now.tile_limit - 1));
		map_w = int'(regs_now.map_width) << TSX;
		map_h = int'(regs_now.map_height) << TSY;
		if (r.kind == tmsv_pkg::REQ_SET) begin
			r.x = pick_coord(0, scroll_limit(32'(regs_now.map_width), TSX,
				32'(regs_now.view_width)));
			r.y = pick_coord(0, scroll_limit(32'(regs_now.map_height), TSY,
				32'(regs_now.view_height)));
		end else if (r.space == tmsv_pkg::SP_SCREEN) begin
			r.x = pick_coord(32'(regs_now.view_left), 32'(regs_now.view_width));
			r.y = pick_coord(32'(regs_now.view_top), 32'(regs_now.view_height));
		end else if (r.space == tmsv_pkg::SP_VIEW) begin
			r.x = pick_coord(0, 32'(regs_now.view_width));
			r.y = pick_coord(0, 32'(regs_now.view_height));
		end else begin
			r.x = pick_coord(0, map_w);
			r.y = pick_coord(0, map_h);
		end
		return r;
	endfunction

	// one request word, with optional idle cycles ahead of it
	task automatic send_req(req_t r);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= r.kind;
		coord_space <= r.space;
		dir_mask <= r.dirs;
		step_count <= r.steps;
		pos_x <= r.x;
		pos_y <= r.y;
		tile_value <= r.tile;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		due_views.push_back(predict_layer(r));
		requests_sent++;
	endtask

	task automatic wait_all_results();
		in_valid <= 1'b0;
		while (due_views.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] index, logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (index)
		tmsv_pkg::REG_MAP_WIDTH:  regs_now.map_width = value[tmsv_pkg::DIM_W-1:0];
		tmsv_pkg::REG_MAP_HEIGHT: regs_now.map_height = value[tmsv_pkg::DIM_W-1:0];
		tmsv_pkg::REG_VIEW_LEFT:  regs_now.view_left = value;
		tmsv_pkg::REG_VIEW_TOP:   regs_now.view_top = value;
		tmsv_pkg::REG_VIEW_W:     regs_now.view_width = value;
		tmsv_pkg::REG_VIEW_H:     regs_now.view_height = value;
		tmsv_pkg::REG_TILE_LIMIT: regs_now.tile_limit = value;
		default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(int unsigned mw, int unsigned mh, int unsigned vl,
			int unsigned vt, int unsigned vw, int unsigned vh, int unsigned lim);
		wait_all_results();
		write_reg(tmsv_pkg::REG_MAP_WIDTH, 16'(mw));
		write_reg(tmsv_pkg::REG_MAP_HEIGHT, 16'(mh));
		write_reg(tmsv_pkg::REG_VIEW_LEFT, 16'(vl));
		write_reg(tmsv_pkg::REG_VIEW_TOP, 16'(vt));
		write_reg(tmsv_pkg::REG_VIEW_W, 16'(vw));
		write_reg(tmsv_pkg::REG_VIEW_H, 16'(vh));
		write_reg(tmsv_pkg::REG_TILE_LIMIT, 16'(lim));
		settings_used++;
	endtask

	task automatic run_random(int n, int idle, int stall);
		send_idle_pct = idle;
		stall_pct = stall;
		repeat (n) send_req(random_request());
	endtask

	// store limits, clamps from both sides, scroll above the limit, odd spaces
	task automatic test_directed();
		send_idle_pct = 0;
		stall_pct = 0;
		send_req(make_req(tmsv_pkg::REQ_READ, tmsv_pkg::SP_MAP, 4'd0, 10'd0,
			16'd0, 16'd0, 16'd0));
		send_req(make_req(tmsv_pkg::REQ_WRITE, tmsv_pkg::SP_MAP, 4'd0, 10'd0,
			16'd8, 16'd0, 16'd255));
		send_req(make_req(tmsv_pkg::REQ_READ, tmsv_pkg::SP_MAP, 4'd0, 10'd0,
			16'd8, 16'd0, 16'd0));
		send_req(make_req(tmsv_pkg::REQ_WRITE, tmsv_pkg::SP_MAP, 4'd0, 10'd0,
			16'd16, 16'd0, 16'd256));
		send_req(make_req(tmsv_pkg::REQ_WRITE, tmsv_pkg::SP_MAP, 4'd0, 10'd0,
			16'd16, 16'd0, 16'hffff));
		send_req(make_req(tmsv_pkg::REQ_READ, tmsv_pkg::SP_MAP, 4'd0, 10'd0,
			16'd16, 16'd0, 16'd0));
		send_req(make_req(tmsv_pkg::REQ_READ, tmsv_pkg::SP_MAP, 4'd0, 10'd0,
			16'd511, 16'd511, 16'd0));
		send_req(make_req(tmsv_pkg::REQ_READ, tmsv_pkg::SP_MAP, 4'd0, 10'd0,
			16'd512, 16'd0, 16'd0));
		send_req(make_req(tmsv_pkg::REQ_READ, tmsv_pkg::SP_MAP, 4'd0, 10'd0,
			16'hffff, 16'hffff, 16'd0));
		send_req(make_req(tmsv_pkg::REQ_READ, SP_NONE, 4'd0, 10'd0,
			16'd0, 16'd0, 16'd0));
		send_req(make_req(tmsv_pkg::REQ_WRITE, SP_NONE, 4'd0, 10'd0,
			16'd0, 16'd0, 16'd1));
		send_req(make_req(tmsv_pkg::REQ_REL, tmsv_pkg::SP_MAP, 4'hf, 10'd0,
			16'd0, 16'd0, 16'd0));
		send_req(make_req(tmsv_pkg::REQ_REL, tmsv_pkg::SP_MAP, DIR_UP, 10'd1,
			16'd0, 16'd0, 16'd0));
		send_req(make_req(tmsv_pkg::REQ_REL, tmsv_pkg::SP_MAP, DIR_DOWN, 10'd1023,
			16'd0, 16'd0, 16'd0));
		send_req(make_req(tmsv_pkg::REQ_REL, tmsv_pkg::SP_MAP, DIR_RIGHT, 10'd1023,
			16'd0, 16'd0, 16'd0));
		send_req(make_req(tmsv_pkg::REQ_REL, tmsv_pkg::SP_MAP, 4'hf, 10'd5,
			16'd0, 16'd0, 16'd0));
		send_req(make_req(tmsv_pkg::REQ_SET, tmsv_pkg::SP_MAP, 4'd0, 10'd0,
			16'hffff, 16'hffff, 16'd0));
		send_req(make_req(tmsv_pkg::REQ_REL, tmsv_pkg::SP_MAP, DIR_DOWN | DIR_RIGHT, 10'd0,
			16'd0, 16'd0, 16'd0));
		send_req(make_req(tmsv_pkg::REQ_REL, tmsv_pkg::SP_MAP, DIR_DOWN | DIR_RIGHT, 10'd1,
			16'd0, 16'd0, 16'd0));
		send_req(make_req(tmsv_pkg::REQ_REL, tmsv_pkg::SP_MAP, DIR_UP | DIR_LEFT, 10'd1023,
			16'd0, 16'd0, 16'd0));
		send_req(make_req(tmsv_pkg::REQ_SET, tmsv_pkg::SP_MAP, 4'd0, 10'd0,
			16'd7, 16'd15, 16'd0));
		send_req(make_req(tmsv_pkg::REQ_READ, tmsv_pkg::SP_VIEW, 4'd0, 10'd0,
			16'd1, 16'd1, 16'd0));
		send_req(make_req(tmsv_pkg::REQ_WRITE, tmsv_pkg::SP_VIEW, 4'd0, 10'd0,
			16'hffff, 16'd0, 16'd3));
		send_req(make_req(tmsv_pkg::REQ_READ, tmsv_pkg::SP_SCREEN, 4'd0, 10'd0,
			16'd319, 16'd239, 16'd0));
		send_req(make_req(tmsv_pkg::REQ_READ, tmsv_pkg::SP_SCREEN, 4'd0, 10'd0,
			16'd320, 16'd0, 16'd0));
	endtask

	task automatic test_default_map();
		run_random(220, 0, 0);
	endtask

	task automatic test_small_map_offset_view();
		apply_setting(16, 12, 40, 30, 100, 70, 1000);
		run_random(220, 59, 0);
	endtask

	// map far larger than the store, one-pixel window at the screen corner
	task automatic test_huge_map_tiny_view();
		apply_setting(4096, 4096, 65535, 65535, 1, 1, 65535);
		run_random(220, 0, 59);
	endtask

	// one tile map under a full-size view, only tile code 0 allowed
	task automatic test_single_tile_map();
		apply_setting(1, 1, 0, 0, 65535, 65535, 1);
		run_random(220, 38, 38);
	endtask

	// results held back long enough for the queue to fill and stall input
	task automatic test_full_queue();
		apply_setting(64, 64, 0, 0, 320, 240, 256);
		send_idle_pct = 0;
		stall_pct = 0;
		@(negedge clk);
		hold_left = 300;
		@(posedge clk);
		repeat (40) send_req(random_request());
		wait_all_results();
	endtask

	// result side: random stalls, plus a long hold when asked
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	function automatic void check_field(string what, int unsigned want, int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
		end
	endfunction

	// every result word against the oldest prediction
	always @(posedge clk) begin
		layer_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (due_views.size() == 0) begin
				mismatches++;
				$display("%0t: result word arrived with nothing expected", $time);
			end else begin
				want = due_views.pop_front();
				check_field("edge_flags", 32'(want.edges), 32'(edge_flags));
				check_field("tile_read", 32'(want.rd), 32'(tile_read));
				check_field("outside", 32'(want.miss), 32'(outside));
				check_field("first_col", 32'(want.col), 32'(first_col));
				check_field("first_row", 32'(want.row), 32'(first_row));
				check_field("fine_x", 32'(want.fx), 32'(fine_x));
				check_field("fine_y", 32'(want.fy), 32'(fine_y));
				check_field("cols_to_draw", 32'(want.ncols), 32'(cols_to_draw));
				check_field("rows_to_draw", 32'(want.nrows), 32'(rows_to_draw));
				check_field("scroll_now_x", 32'(want.sx), 32'(scroll_now_x));
				check_field("scroll_now_y", 32'(want.sy), 32'(scroll_now_y));
			end
		end
	end

	initial begin
		#400_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		regs_now = '{map_width: 64, map_height: 64, view_left: 0, view_top: 0,
			view_width: 320, view_height: 240, tile_limit: 256};
		scroll_x = 0;
		scroll_y = 0;
		foreach (tile_mirror[i])
			tile_mirror[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_default_map();
		test_small_map_offset_view();
		test_huge_map_tiny_view();
		test_single_tile_map();
		test_full_queue();

		wait_all_results();
		repeat (8) @(posedge clk);
		if (due_views.size() != 0) begin
			mismatches++;
			$display("%0t: %0d expected result words never arrived", $time, due_views.size());
		end
		$display("Ran %0d requests of all kinds and coordinate spaces over %0d register settings,",
			requests_sent, settings_used);
		$display("with mixed idle and stall rates and one long result hold-off.");
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
`default_nettype wire

[filelist.f]
+incdir+hdl
hdl/tmsv_pkg.sv
hdl/tmsv_front.sv
hdl/tmsv_queue.sv
hdl/tmsv_back.sv
hdl/tile_map_scroll_viewport_core.sv
test/testbench.sv
